>>> hdl/plp_pkg.sv
// Shared types, constants and fixed-point helpers for the look-vector projection block.
// Used by the rotation stage, the divider and the top level; depends on nothing.
package plp_pkg;

    // Quotient bits kept by the divider: offsets clamp at 2^40.
    localparam int Q_BITS  = 41;
    localparam int DIV_LAT = Q_BITS + 1;
    localparam logic [Q_BITS-1:0] OFF_LIMIT = Q_BITS'(64'd1 << 40);

    // Configuration register indexes.
    typedef enum logic [7:0] {
        CFG_ROT_W        = 8'd0,
        CFG_ROT_X        = 8'd1,
        CFG_ROT_Y        = 8'd2,
        CFG_ROT_Z        = 8'd3,
        CFG_LINE_SCALE   = 8'd4,
        CFG_SAMPLE_SCALE = 8'd5,
        CFG_LINE_COUNT   = 8'd6,
        CFG_SAMPLE_COUNT = 8'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
        logic               band;
    } t_in;

    typedef struct packed {
        logic signed [31:0] line_pos;
        logic signed [31:0] sample_pos;
        logic               zero_depth;
        logic               band_error;
    } t_out;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_quat;

    // Per-item control that travels alongside the data.
    typedef struct packed {
        logic valid;
        logic band;
        logic zero;
        logic neg_l;
        logic neg_s;
    } t_tag;

    // Round a Q2.60 product to Q.30: add half, shift right arithmetically.
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd536870912) >>> 30;
        return s[33:0];
    endfunction

    // Saturate a sum to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

>>> hdl/pinhole_look_to_frame_projection.sv
// Top level of the pinhole look-vector to frame-coordinate projection.
// Depends on plp_pkg, plp_rotate and plp_divider.
//
// A look vector in Q1.30 is rotated into the camera frame by the configured quaternion,
// its lateral parts are divided by depth and scaled, and half the detector size is added
// to give saturated signed frame coordinates with COORD_FRAC_BITS fraction bits. One item
// is accepted every cycle while the output side takes results; each result passes through
// the four rotation stages, one scaling multiply stage, the 42-stage divider (an entry
// stage, then one quotient bit per stage) and the output register. The whole pipeline
// holds as one when a finished result is not taken. Configuration is written through its
// own port, always ready, and should change only while the block is empty.
module pinhole_look_to_frame_projection import plp_pkg::*; #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = 16 + COORD_FRAC_BITS;

    t_quat              r_quat;
    logic [31:0]        r_line_scale, r_sample_scale;
    logic [15:0]        r_line_count, r_sample_count;
    logic               w_en;
    t_tag               w_in_tag;
    t_tag               w_rot_tag;
    logic signed [31:0] w_fx, w_fy, w_fz;
    logic [31:0]        w_mx, w_my, w_mz;
    logic [63:0]        r_num_l, r_num_s;
    logic [31:0]        r_mdep;
    t_tag               r_tag5, n_tag5;
    t_tag               r_tag [DIV_LAT];
    logic [Q_BITS-1:0]  w_q_l, w_q_s;
    logic               w_ovf_l, w_ovf_s;
    t_out               r_out, n_out;
    logic               r_out_valid;

    // The whole pipeline moves unless a finished result is waiting.
    assign w_en        = !r_out_valid || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w       <= 32'sh40000000;
            r_quat.x       <= '0;
            r_quat.y       <= '0;
            r_quat.z       <= '0;
            r_line_scale   <= '0;
            r_sample_scale <= '0;
            r_line_count   <= 16'd1;
            r_sample_count <= 16'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROT_W:        r_quat.w       <= i_cfg_data;
                CFG_ROT_X:        r_quat.x       <= i_cfg_data;
                CFG_ROT_Y:        r_quat.y       <= i_cfg_data;
                CFG_ROT_Z:        r_quat.z       <= i_cfg_data;
                CFG_LINE_SCALE:   r_line_scale   <= i_cfg_data;
                CFG_SAMPLE_SCALE: r_sample_scale <= i_cfg_data;
                CFG_LINE_COUNT:   r_line_count   <= i_cfg_data[15:0];
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Rotation into the camera frame.
    always_comb begin
        w_in_tag       = '0;
        w_in_tag.valid = i_valid;
        w_in_tag.band  = i_item.band;
    end

    plp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_in_tag),
        .i_look  (i_item),
        .i_quat  (r_quat),
        .o_tag   (w_rot_tag),
        .o_fx    (w_fx),
        .o_fy    (w_fy),
        .o_fz    (w_fz)
    );

    // Magnitudes, signs and the scale multiplies.
    assign w_mx = w_fx[31] ? 32'(-w_fx) : 32'(w_fx);
    assign w_my = w_fy[31] ? 32'(-w_fy) : 32'(w_fy);
    assign w_mz = w_fz[31] ? 32'(-w_fz) : 32'(w_fz);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num_l <= 64'(w_mx) * 64'(r_line_scale);
            r_num_s <= 64'(w_my) * 64'(r_sample_scale);
            r_mdep  <= w_mz;
        end
    end

    // Tag for the scaling stage, with the depth flag and the result signs.
    always_comb begin
        n_tag5       = w_rot_tag;
        n_tag5.zero  = (w_fz == 32'sd0);
        n_tag5.neg_l = w_fx[31] ^ w_fz[31];
        n_tag5.neg_s = w_fy[31] ^ w_fz[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag5 <= '0;
        end else if (w_en) begin
            r_tag5 <= n_tag5;
        end
    end

    // Division of scaled lateral magnitude by depth, one lane per axis.
    plp_divider #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_line (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_num_l),
        .i_mdep (r_mdep),
        .o_q    (w_q_l),
        .o_ovf  (w_ovf_l)
    );

    plp_divider #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_sample (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_num_s),
        .i_mdep (r_mdep),
        .o_q    (w_q_s),
        .o_ovf  (w_ovf_s)
    );

    // Tag delay line matching the divider latency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_tag[i] <= '0;
            end
        end else if (w_en) begin
            r_tag[0] <= r_tag5;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    // Clamp, apply sign, add the centre and saturate.
    function automatic logic signed [31:0] place(input logic [Q_BITS-1:0] q,
                                                 input logic ovf,
                                                 input logic neg,
                                                 input logic [15:0] count);
        logic [Q_BITS-1:0]  mag;
        logic signed [42:0] off;
        logic signed [42:0] centre;
        logic signed [42:0] sum;
        mag    = (ovf || q > OFF_LIMIT) ? OFF_LIMIT : q;
        off    = neg ? -43'(mag) : 43'(mag);
        centre = 43'(CW'(count) << COORD_FRAC_BITS) >>> 1;
        sum    = centre + off;
        if (sum > 43'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (sum < -43'sd2147483648) begin
            return 32'sh80000000;
        end
        return sum[31:0];
    endfunction

    always_comb begin
        n_out.zero_depth = r_tag[DIV_LAT-1].zero;
        n_out.band_error = r_tag[DIV_LAT-1].band;
        n_out.line_pos   = '0;
        n_out.sample_pos = '0;
        if (!r_tag[DIV_LAT-1].zero && !r_tag[DIV_LAT-1].band) begin
            n_out.line_pos   = place(w_q_l, w_ovf_l, r_tag[DIV_LAT-1].neg_l, r_line_count);
            n_out.sample_pos = place(w_q_s, w_ovf_s, r_tag[DIV_LAT-1].neg_s,
                                     r_sample_count);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_tag[DIV_LAT-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // A flagged result never carries coordinates.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.zero_depth || o_item.band_error)
        |-> o_item.line_pos == 32'sd0 && o_item.sample_pos == 32'sd0)
        else $error("flagged result carries nonzero coordinates");

    // Input side stalls only while a result waits untaken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a waiting result");

    // A new result comes only from a valid item leaving the divider.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_tag[DIV_LAT-1].valid))
        else $error("result appeared without a valid item");

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("waiting result changed");

endmodule

>>> hdl/plp_rotate.sv
// Four-stage quaternion rotation f = conj(q) * v * q in Q1.30.
// Depends on plp_pkg for the payload types and rounding helpers.
module plp_rotate import plp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_tag               i_tag,
    input  t_in                i_look,
    input  t_quat              i_quat,
    output t_tag               o_tag,
    output logic signed [31:0] o_fx,
    output logic signed [31:0] o_fy,
    output logic signed [31:0] o_fz
);

    logic signed [63:0] r_p1 [12];
    logic signed [63:0] n_p1 [12];
    logic signed [63:0] r_p2 [12];
    logic signed [63:0] n_p2 [12];
    logic signed [31:0] r_t [4];
    logic signed [31:0] n_t [4];
    logic signed [31:0] r_fx, r_fy, r_fz;
    logic signed [31:0] n_fx, n_fy, n_fz;
    t_tag               r_tag [4];
    logic signed [33:0] rq1 [12];
    logic signed [33:0] rq2 [12];

    // First product stage: conj(q) times the pure vector.
    always_comb begin
        n_p1[0]  = 64'(i_quat.x) * 64'(i_look.look_x);
        n_p1[1]  = 64'(i_quat.y) * 64'(i_look.look_y);
        n_p1[2]  = 64'(i_quat.z) * 64'(i_look.look_z);
        n_p1[3]  = 64'(i_quat.w) * 64'(i_look.look_x);
        n_p1[4]  = 64'(i_quat.y) * 64'(i_look.look_z);
        n_p1[5]  = 64'(i_quat.z) * 64'(i_look.look_y);
        n_p1[6]  = 64'(i_quat.w) * 64'(i_look.look_y);
        n_p1[7]  = 64'(i_quat.x) * 64'(i_look.look_z);
        n_p1[8]  = 64'(i_quat.z) * 64'(i_look.look_x);
        n_p1[9]  = 64'(i_quat.w) * 64'(i_look.look_z);
        n_p1[10] = 64'(i_quat.x) * 64'(i_look.look_y);
        n_p1[11] = 64'(i_quat.y) * 64'(i_look.look_x);
    end

    // Round and sum the first products into t.
    always_comb begin
        for (int i = 0; i < 12; i++) begin
            rq1[i] = rnd30(r_p1[i]);
        end
        n_t[0] = sat32(36'(rq1[0]) + 36'(rq1[1]) + 36'(rq1[2]));
        n_t[1] = sat32(36'(rq1[3]) - 36'(rq1[4]) + 36'(rq1[5]));
        n_t[2] = sat32(36'(rq1[6]) + 36'(rq1[7]) - 36'(rq1[8]));
        n_t[3] = sat32(36'(rq1[9]) - 36'(rq1[10]) + 36'(rq1[11]));
    end

    // Second product stage: t times q.
    always_comb begin
        n_p2[0]  = 64'(r_t[0]) * 64'(i_quat.x);
        n_p2[1]  = 64'(r_t[1]) * 64'(i_quat.w);
        n_p2[2]  = 64'(r_t[2]) * 64'(i_quat.z);
        n_p2[3]  = 64'(r_t[3]) * 64'(i_quat.y);
        n_p2[4]  = 64'(r_t[0]) * 64'(i_quat.y);
        n_p2[5]  = 64'(r_t[1]) * 64'(i_quat.z);
        n_p2[6]  = 64'(r_t[2]) * 64'(i_quat.w);
        n_p2[7]  = 64'(r_t[3]) * 64'(i_quat.x);
        n_p2[8]  = 64'(r_t[0]) * 64'(i_quat.z);
        n_p2[9]  = 64'(r_t[1]) * 64'(i_quat.y);
        n_p2[10] = 64'(r_t[2]) * 64'(i_quat.x);
        n_p2[11] = 64'(r_t[3]) * 64'(i_quat.w);
    end

    // Round and sum the second products into the vector part of f.
    always_comb begin
        for (int i = 0; i < 12; i++) begin
            rq2[i] = rnd30(r_p2[i]);
        end
        n_fx = sat32(36'(rq2[0]) + 36'(rq2[1]) + 36'(rq2[2]) - 36'(rq2[3]));
        n_fy = sat32(36'(rq2[4]) - 36'(rq2[5]) + 36'(rq2[6]) + 36'(rq2[7]));
        n_fz = sat32(36'(rq2[8]) + 36'(rq2[9]) - 36'(rq2[10]) + 36'(rq2[11]));
    end

    // Data registers advance together whenever the pipeline moves.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= n_p1;
            r_t  <= n_t;
            r_p2 <= n_p2;
            r_fx <= n_fx;
            r_fy <= n_fy;
            r_fz <= n_fz;
        end
    end

    // Tags with valid bits travel beside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_tag[i] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < 4; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    assign o_tag = r_tag[3];
    assign o_fx  = r_fx;
    assign o_fy  = r_fy;
    assign o_fz  = r_fz;

endmodule

>>> hdl/plp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Depends on plp_pkg for the quotient width; scaling follows the fraction-bit parameter.
module plp_divider import plp_pkg::*; #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [63:0]       i_num,
    input  logic [31:0]       i_mdep,
    output logic [Q_BITS-1:0] o_q,
    output logic              o_ovf
);

    localparam int UP = (COORD_FRAC_BITS > 12) ? COORD_FRAC_BITS - 12 : 0;
    localparam int DN = (COORD_FRAC_BITS < 12) ? 12 - COORD_FRAC_BITS : 0;
    localparam int NW = 64 + UP;
    localparam int DW = 32 + DN;

    logic [NW-1:0]     w_n;
    logic [DW-1:0]     w_d;
    logic [DW-1:0]     w_hi;
    logic [DW-1:0]     r_rem [Q_BITS+1];
    logic [DW-1:0]     r_d   [Q_BITS+1];
    logic [Q_BITS-1:0] r_low [Q_BITS+1];
    logic [Q_BITS-1:0] r_q   [Q_BITS+1];
    logic              r_ovf [Q_BITS+1];

    // Scale numerator and denominator, and check whether the quotient reaches 2^41.
    assign w_n  = NW'(i_num) << UP;
    assign w_d  = DW'(i_mdep) << DN;
    assign w_hi = DW'(w_n[NW-1:Q_BITS]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_hi;
            r_d[0]   <= w_d;
            r_low[0] <= w_n[Q_BITS-1:0];
            r_q[0]   <= '0;
            r_ovf[0] <= (w_hi >= w_d);
        end
    end

    // One restoring step per stage: shift in a numerator bit, subtract if it fits.
    for (genvar k = 0; k < Q_BITS; k++) begin : g_step
        logic [DW:0] w_trial;
        logic [DW:0] w_diff;
        logic        w_bit;

        assign w_trial = {r_rem[k], r_low[k][Q_BITS-1]};
        assign w_diff  = w_trial - {1'b0, r_d[k]};
        assign w_bit   = (w_trial >= {1'b0, r_d[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_bit ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_d[k+1]   <= r_d[k];
                r_low[k+1] <= r_low[k] << 1;
                r_q[k+1]   <= {r_q[k][Q_BITS-2:0], w_bit};
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_q   = r_q[Q_BITS];
    assign o_ovf = r_ovf[Q_BITS];

endmodule
